[rtl/svp_pkg.sv]
// Shared types, codes and coil table for the stepper valve positioner.
package svp_pkg;

  // Operation codes of the input item
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  // Configuration register indexes
  localparam logic REG_STEPS_PER_POSITION = 1'b0;
  localparam logic REG_HIGHEST_POSITION   = 1'b1;

  localparam int SPP_W = 12;
  localparam int POS_W = 3;
  localparam int PHASE_W = 3;
  localparam int COIL_W = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [SPP_W-1:0] SPP_RESET = 12'd683;
  localparam logic [POS_W-1:0] HIGHEST_RESET = 3'd5;

  // Result of the move planner, handed to the state update
  typedef struct packed {
    logic             start;
    logic             dir;
    logic [POS_W-1:0] goal;
  } move_plan_t;

  // Half-step coil pattern for each phase
  function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

[rtl/svp_channels.sv]
// Valid/ready channel interfaces for command input and status output.
interface svp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] target_pos;

  modport source (output valid, output op, output target_pos, input ready);
  modport sink (input valid, input op, input target_pos, output ready);
endinterface

interface svp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic       busy_res;
  logic [2:0] position;
  logic       rejected;

  modport source (output valid, output coils, output busy_res, output position,
                  output rejected, input ready);
  modport sink (input valid, input coils, input busy_res, input position,
                input rejected, output ready);
endinterface

[rtl/svp_move_calc.sv]
// Move planner: clamp the target, pick the direction and size the step count.
module svp_move_calc #(
  parameter int STEP_COUNT_BITS = 12
) (
  input  logic [svp_pkg::POS_W-1:0] target_pos,
  input  logic [svp_pkg::POS_W-1:0] current_position,
  input  logic [svp_pkg::POS_W-1:0] highest_position,
  input  logic [svp_pkg::SPP_W-1:0] steps_per_position,
  output svp_pkg::move_plan_t       plan,
  output logic [STEP_COUNT_BITS-1:0] step_count
);

  localparam int PROD_W = svp_pkg::POS_W + svp_pkg::SPP_W;
  localparam int EXT_W = (STEP_COUNT_BITS > PROD_W) ? STEP_COUNT_BITS : PROD_W;

  logic [svp_pkg::POS_W-1:0] clamped;
  logic [svp_pkg::POS_W-1:0] span;
  logic [PROD_W-1:0]         product;
  logic [EXT_W-1:0]          product_ext;
  logic [EXT_W-1:0]          count_max;

  always_comb begin
    clamped = (target_pos > highest_position) ? highest_position : target_pos;
    plan.goal = clamped;
    plan.start = (clamped != current_position);
    plan.dir = (clamped < current_position);
    span = plan.dir ? (current_position - clamped) : (clamped - current_position);
    product = PROD_W'(span) * PROD_W'(steps_per_position);
    product_ext = EXT_W'(product);
    count_max = EXT_W'({STEP_COUNT_BITS{1'b1}});
    // Saturate a count that does not fit the step counter
    if (product_ext > count_max) begin
      step_count = {STEP_COUNT_BITS{1'b1}};
    end else begin
      step_count = product_ext[STEP_COUNT_BITS-1:0];
    end
  end

endmodule

[rtl/stepper_valve_positioner.sv]
// Latency: a result is valid the cycle after its command transaction is accepted.
// Throughput: one command per cycle unless stalled; the state update and the
// step-count multiply sit between the accepted command and one result register.
// Input ready stays high while the result register is empty or being drained.
// Reset (rst, synchronous): coils off, position 0, idle, phase 0, result empty,
// steps_per_position 683 and highest_position 5.
module stepper_valve_positioner #(
  parameter int STEP_COUNT_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  svp_in_if.sink                         in_ch,
  svp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [svp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [svp_pkg::SPP_W-1:0] steps_per_position;
  logic [svp_pkg::POS_W-1:0] highest_position;

  // Positioner state
  logic [svp_pkg::POS_W-1:0]   current_position, current_position_next;
  logic [svp_pkg::POS_W-1:0]   goal_position, goal_position_next;
  logic [STEP_COUNT_BITS-1:0]  steps_left, steps_left_next;
  logic                        step_direction, step_direction_next;
  logic [svp_pkg::PHASE_W-1:0] coil_phase, coil_phase_next;
  logic                        moving, moving_next;
  logic [svp_pkg::COIL_W-1:0]  coil_drive, coil_drive_next;
  logic                        rejected_next;

  // Result register
  logic                        res_valid;
  logic [svp_pkg::COIL_W-1:0]  res_coils;
  logic                        res_busy;
  logic [svp_pkg::POS_W-1:0]   res_position;
  logic                        res_rejected;

  logic                        accept;
  svp_pkg::move_plan_t         plan;
  logic [STEP_COUNT_BITS-1:0]  step_count;

  // Take a new transaction whenever the result register is free or draining
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  svp_move_calc #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS)
  ) u_move_calc (
    .target_pos         (in_ch.target_pos),
    .current_position   (current_position),
    .highest_position   (highest_position),
    .steps_per_position (steps_per_position),
    .plan               (plan),
    .step_count         (step_count)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_position <= svp_pkg::SPP_RESET;
      highest_position <= svp_pkg::HIGHEST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        svp_pkg::REG_STEPS_PER_POSITION: steps_per_position <= cfg_data[svp_pkg::SPP_W-1:0];
        svp_pkg::REG_HIGHEST_POSITION:   highest_position <= cfg_data[svp_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // State update for the accepted command
  always_comb begin
    current_position_next = current_position;
    goal_position_next = goal_position;
    steps_left_next = steps_left;
    step_direction_next = step_direction;
    coil_phase_next = coil_phase;
    moving_next = moving;
    coil_drive_next = coil_drive;
    rejected_next = 1'b0;
    case (in_ch.op)
      svp_pkg::OP_TICK: begin
        if (moving) begin
          if (steps_left != '0) begin
            // Advance one half-step in the move direction
            coil_phase_next = step_direction ? (coil_phase - 3'd1) : (coil_phase + 3'd1);
            coil_drive_next = svp_pkg::half_step_pattern(coil_phase_next);
            steps_left_next = steps_left - STEP_COUNT_BITS'(1);
          end else begin
            // Last step done: drop the coils and commit the goal
            coil_drive_next = '0;
            current_position_next = goal_position;
            moving_next = 1'b0;
          end
        end
      end
      svp_pkg::OP_MOVE: begin
        if (moving) begin
          rejected_next = 1'b1;
        end else if (plan.start) begin
          step_direction_next = plan.dir;
          steps_left_next = step_count;
          goal_position_next = plan.goal;
          moving_next = 1'b1;
        end
      end
      svp_pkg::OP_HOME: begin
        if (moving) begin
          rejected_next = 1'b1;
        end else begin
          current_position_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
      goal_position <= '0;
      steps_left <= '0;
      step_direction <= 1'b0;
      coil_phase <= '0;
      moving <= 1'b0;
      coil_drive <= '0;
    end else if (accept) begin
      current_position <= current_position_next;
      goal_position <= goal_position_next;
      steps_left <= steps_left_next;
      step_direction <= step_direction_next;
      coil_phase <= coil_phase_next;
      moving <= moving_next;
      coil_drive <= coil_drive_next;
    end
  end

  // Result register: load on accept, clear valid once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_coils <= coil_drive_next;
      res_busy <= moving_next;
      res_position <= current_position_next;
      res_rejected <= rejected_next;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.coils = res_coils;
  assign out_ch.busy_res = res_busy;
  assign out_ch.position = res_position;
  assign out_ch.rejected = res_rejected;

`ifndef NO_ASSERTIONS
  // Coils are off whenever no move is running
  a_idle_coils_off: assert property (@(posedge clk) disable iff (rst)
    !moving |-> coil_drive == '0)
    else $error("coils driven while idle");

  // A move or home during a move is reported as rejected
  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && moving && (in_ch.op == svp_pkg::OP_MOVE || in_ch.op == svp_pkg::OP_HOME))
    |=> res_valid && res_rejected && res_busy)
    else $error("command during move not rejected");

  // A tick with steps left energizes some coil
  a_step_drives: assert property (@(posedge clk) disable iff (rst)
    (accept && moving && in_ch.op == svp_pkg::OP_TICK && steps_left != '0)
    |=> coil_drive != '0 && moving)
    else $error("step tick left coils off");

  // Position only changes at the end of a move while moving
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (moving && !(accept && in_ch.op == svp_pkg::OP_TICK && steps_left == '0))
    |=> $stable(current_position))
    else $error("position changed during move");
`endif

endmodule
